>>> hw/rtl/rlbd_pkg.sv
// Shared types, constants and the control program of the run-length bitmap decoder.
package rlbd_pkg;

	localparam int MAX_RESULTS = 33;
	localparam int CNT_W       = 6;

	localparam logic [2:0] COND_NEVER  = 3'd0;
	localparam logic [2:0] COND_ALWAYS = 3'd1;
	localparam logic [2:0] COND_NOIN   = 3'd2;
	localparam logic [2:0] COND_FIN    = 3'd3;
	localparam logic [2:0] COND_BUSY   = 3'd4;
	localparam logic [2:0] COND_HELD   = 3'd5;

	localparam logic [2:0] STEP_WAIT  = 3'd0;
	localparam logic [2:0] STEP_LDA   = 3'd1;
	localparam logic [2:0] STEP_RUNA  = 3'd2;
	localparam logic [2:0] STEP_TOGA  = 3'd3;
	localparam logic [2:0] STEP_RUNB  = 3'd4;
	localparam logic [2:0] STEP_TOGB  = 3'd5;
	localparam logic [2:0] STEP_FLUSH = 3'd6;

	typedef struct packed {
		logic       accept;
		logic       load;
		logic       load_sel;
		logic       run;
		logic       toggle;
		logic       flush;
		logic [2:0] stay_on;
		logic [2:0] br_on;
		logic [2:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic busy;
		logic fin;
		logic held;
	} seq_status_t;

	typedef struct packed {
		logic [7:0] pixels;
		logic [6:0] column;
		logic [2:0] page;
		logic       done;
	} result_t;

	function automatic ctrl_word_t rom(input logic [2:0] step);
		ctrl_word_t w;
		w = '0;
		case (step)
			STEP_WAIT: begin
				w.accept  = 1'b1;
				w.stay_on = COND_NOIN;
			end
			STEP_LDA: begin
				w.load   = 1'b1;
				w.br_on  = COND_FIN;
				w.target = STEP_FLUSH;
			end
			STEP_RUNA: begin
				w.run     = 1'b1;
				w.stay_on = COND_BUSY;
			end
			STEP_TOGA: begin
				w.toggle   = 1'b1;
				w.load     = 1'b1;
				w.load_sel = 1'b1;
				w.br_on    = COND_FIN;
				w.target   = STEP_FLUSH;
			end
			STEP_RUNB: begin
				w.run     = 1'b1;
				w.stay_on = COND_BUSY;
			end
			STEP_TOGB: begin
				w.toggle = 1'b1;
			end
			STEP_FLUSH: begin
				w.flush   = 1'b1;
				w.stay_on = COND_HELD;
				w.br_on   = COND_ALWAYS;
				w.target  = STEP_WAIT;
			end
			default: begin
				w.br_on  = COND_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/rlbd_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module rlbd_seq
	import rlbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output ctrl_word_t  ctrl,
	output logic [2:0]  step
);

	logic [2:0] pc_q;
	logic       stay;
	logic       br;

	function automatic logic cond_eval(input logic [2:0] c, input seq_status_t s);
		logic r;
		r = 1'b0;
		case (c)
			COND_NEVER:  r = 1'b0;
			COND_ALWAYS: r = 1'b1;
			COND_NOIN:   r = !s.in_valid;
			COND_FIN:    r = s.fin;
			COND_BUSY:   r = s.busy;
			COND_HELD:   r = s.held;
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

	assign ctrl = rom(pc_q);
	assign step = pc_q;
	assign stay = cond_eval(ctrl.stay_on, status);
	assign br   = cond_eval(ctrl.br_on, status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else if (stay) begin
			pc_q <= pc_q;
		end else if (br) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + 3'd1;
		end
	end

endmodule

>>> hw/rtl/run_length_bitmap_decoder.sv
// Top level of the run-length bitmap decoder: sequencer plus pixel packing datapath.
//
// Input stream (s_*): one request per table word, two run codes, high code first;
// s_tuser set clears the decoder (colour, partial byte, column, page, done flag)
// before the word's codes are applied.
// Output stream (m_*): one request per completed byte with its column and page;
// m_tlast marks the last byte caused by a word, m_tuser the final byte of the
// final page. Once the picture is done, words give no bytes until a restart.
// Timing: a word is taken in the wait step; the load, run A, toggle A (also loading
// the second code), run B, toggle B and flush steps follow, each run step taking one
// chunk of its code per cycle, up to the space left in the byte, unless stalled as
// below; the next word is taken in the wait step that follows.
// A completed byte waits in a holding slot until the next byte of the same word
// completes or the flush step, so the last one can be tagged; it shows on the output
// the cycle after that.
// A stalled receiver stops the run steps only when a byte completes and both the
// holding slot and the output register are full, and holds the flush step until the
// output register frees; nothing is dropped.
// Reset returns the sequencer to the wait step and clears the run and output state.
module run_length_bitmap_decoder
	import rlbd_pkg::*;
#(
	parameter int PAGE_BYTES = 128,
	parameter int PAGE_COUNT = 7,
	parameter int CODE_BITS  = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [13:0] table_word
	input  logic        s_tuser,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] pixel_byte, [14:8] column, [17:15] page
	output logic        m_tlast,
	output logic        m_tuser    // [0] picture_done
);

	localparam int COL_W = $clog2(PAGE_BYTES);
	localparam int CX_W  = (COL_W > 7) ? COL_W : 7;
	localparam int REM_W = (CODE_BITS > 4) ? CODE_BITS : 4;
	localparam logic [CODE_BITS-1:0] CODE_MASK = {CODE_BITS{1'b1}};

	ctrl_word_t  ctrl;
	seq_status_t status;
	logic [2:0]  step;

	logic [13:0]          word_q;
	logic [CODE_BITS-1:0] code_q;
	logic [CODE_BITS-1:0] rem_q;
	logic                 colour_q;
	logic [7:0]           partial_q;
	logic [2:0]           bits_q;
	logic [COL_W-1:0]     col_q;
	logic [2:0]           page_q;
	logic                 fin_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_v_q;
	result_t              pend_q;
	logic                 out_v_q;
	result_t              out_q;
	logic                 out_last_q;

	logic [CODE_BITS-1:0] code_a;
	logic [CODE_BITS-1:0] code_b;
	logic [3:0]           space;
	logic [REM_W-1:0]     rem_x;
	logic [REM_W-1:0]     space_x;
	logic [3:0]           take;
	logic                 full;
	logic [7:0]           partial_nx;
	logic                 out_free;
	logic                 chunk_ok;
	logic                 do_run;
	logic                 do_accept;
	logic                 col_end;
	logic                 page_end;
	logic [CX_W-1:0]      col_x;
	result_t              new_res;

	rlbd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.step   (step)
	);

	assign code_a = CODE_BITS'(word_q >> CODE_BITS);
	assign code_b = word_q[CODE_BITS-1:0];

	assign space   = 4'd8 - {1'b0, bits_q};
	assign rem_x   = REM_W'(rem_q);
	assign space_x = REM_W'(space);
	assign full    = rem_x >= space_x;
	assign take    = full ? space : rem_x[3:0];
	assign partial_nx = (partial_q >> take) | (colour_q ? ~(8'hff >> take) : 8'h00);

	assign out_free  = !out_v_q || m_tready;
	assign chunk_ok  = !(full && pend_v_q && !out_free);
	assign do_run    = ctrl.run && (rem_q != '0) && !fin_q && chunk_ok;
	assign do_accept = ctrl.accept && s_tvalid;

	assign col_end  = col_q == COL_W'(PAGE_BYTES - 1);
	assign page_end = page_q == 3'(PAGE_COUNT - 1);
	assign col_x    = CX_W'(col_q);

	assign new_res.pixels = partial_nx;
	assign new_res.column = col_x[6:0];
	assign new_res.page   = page_q;
	assign new_res.done   = col_end && page_end;

	assign status.in_valid = s_tvalid;
	assign status.busy     = (rem_q != '0) && !fin_q;
	assign status.fin      = fin_q;
	assign status.held     = pend_v_q && !out_free;

	assign s_tready = ctrl.accept;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, out_q.page, out_q.column, out_q.pixels};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_q.done;

	always_ff @(posedge clk) begin
		if (do_accept) begin
			word_q <= s_tdata[13:0];
		end
		if (ctrl.load) begin
			code_q <= ctrl.load_sel ? code_b : code_a;
		end
		if (do_run && full && (cnt_q < CNT_W'(MAX_RESULTS))) begin
			pend_q <= new_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			colour_q  <= 1'b0;
			partial_q <= '0;
			bits_q    <= '0;
			col_q     <= '0;
			page_q    <= '0;
			fin_q     <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (do_accept) begin
				cnt_q <= '0;
				rem_q <= '0;
				if (s_tuser) begin
					colour_q  <= 1'b0;
					partial_q <= '0;
					bits_q    <= '0;
					col_q     <= '0;
					page_q    <= '0;
					fin_q     <= 1'b0;
				end
			end
			if (ctrl.load) begin
				rem_q <= ctrl.load_sel ? code_b : code_a;
			end
			if (ctrl.toggle && (code_q != CODE_MASK)) begin
				colour_q <= !colour_q;
			end
			if (do_run) begin
				rem_q  <= rem_q - CODE_BITS'(take);
				bits_q <= bits_q + take[2:0];
				if (full) begin
					partial_q <= '0;
					if (cnt_q < CNT_W'(MAX_RESULTS)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (col_end) begin
						col_q <= '0;
						if (page_end) begin
							page_q <= '0;
							fin_q  <= 1'b1;
						end else begin
							page_q <= page_q + 3'd1;
						end
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end else begin
					partial_q <= partial_nx;
				end
			end
		end
	end

	// one-slot hold-back so the final byte of a word can carry tlast
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (do_run && full && (cnt_q < CNT_W'(MAX_RESULTS))) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q    <= 1'b1;
					out_q      <= pend_q;
					out_last_q <= 1'b0;
				end else if (m_tready) begin
					out_v_q <= 1'b0;
				end
			end else if (ctrl.flush && pend_v_q && out_free) begin
				pend_v_q   <= 1'b0;
				out_v_q    <= 1'b1;
				out_q      <= pend_q;
				out_last_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_v_q)
		else $error("hold slot not empty while waiting for a word");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("result count beyond limit");

	a_done_page: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[17:15] == 3'(PAGE_COUNT - 1)))
		else $error("picture done flagged outside final page");

	a_run_steps: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.run |-> (step == STEP_RUNA || step == STEP_RUNB))
		else $error("run control outside run steps");

endmodule
